### src/smf_pkg.sv
package smf_pkg;

    // Widths fixed by the register map
    localparam int LEN_WIDTH = 5;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE    = 2'd1;

    // Control handed from one sorted cell to the next
    typedef struct packed {
        logic le;          // this cell is active and holds a value <= incoming sample
        logic del_before;  // the expiring entry sits at this cell or below it
    } smf_link_t;

endpackage

### src/smf_cell.sv
module smf_cell import smf_pkg::*; #(
    parameter int W   = 16,
    parameter int AW  = 4,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic          active,
    input  logic          refill,
    input  logic [W-1:0]  refill_val,
    input  logic [W-1:0]  x,
    input  logic [AW-1:0] age_last,
    input  logic [W-1:0]  prev_val,
    input  logic [AW-1:0] prev_age,
    input  smf_link_t     link_in,
    input  logic [W-1:0]  next_val,
    input  logic [AW-1:0] next_age,
    input  logic          next_le,
    output logic [W-1:0]  val_q,
    output logic [AW-1:0] age_q,
    output smf_link_t     link_out
);

    logic [W-1:0]  val_reg, val_next;
    logic [AW-1:0] age_reg, age_next;
    logic          le_self, del_self;
    logic [W-1:0]  s_val, t_val;
    logic [AW-1:0] s_age, t_age;
    logic          s_le, t_le;

    // Compare against the incoming sample and spot the expiring entry
    assign le_self  = active && ($signed(val_reg) <= $signed(x));
    assign del_self = active && (age_reg == age_last);

    assign link_out.le         = le_self;
    assign link_out.del_before = link_in.del_before || del_self;

    // Pick neighbor candidates once the expiring entry is removed
    always_comb begin
        if (link_in.del_before || del_self) begin
            s_val = next_val;
            s_age = next_age;
            s_le  = next_le;
        end else begin
            s_val = val_reg;
            s_age = age_reg;
            s_le  = le_self;
        end
        if (link_in.del_before) begin
            t_val = val_reg;
            t_age = age_reg;
            t_le  = le_self;
        end else begin
            t_val = prev_val;
            t_age = prev_age;
            t_le  = link_in.le;
        end
    end

    // Refill loads the fill value; otherwise insert the new sample at its sorted place, age everything else
    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        if (refill) begin
            val_next = refill_val;
            age_next = AW'(IDX);
        end else if (shift_en && active) begin
            if (s_le) begin
                val_next = s_val;
                age_next = s_age + AW'(1);
            end else if (t_le) begin
                val_next = x;
                age_next = '0;
            end else begin
                val_next = t_val;
                age_next = t_age + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            age_reg <= AW'(IDX);
        end else begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val_q = val_reg;
    assign age_q = age_reg;

endmodule

### src/smf_median.sv
module smf_median import smf_pkg::*; #(
    parameter int W = 16,
    parameter int N = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [N-1:0][W-1:0] vals,
    input  logic [N-1:0]        sel_lo,
    input  logic [N-1:0]        sel_hi,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [W-1:0]        median,
    output logic                can_load
);

    logic [W-1:0] lo, hi;
    logic [W:0]   sum, adj;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [W-1:0] median_reg, median_next;

    // Gather the two middle entries from the sorted row
    always_comb begin
        lo = '0;
        hi = '0;
        for (int i = 0; i < N; i++) begin
            lo = lo | (vals[i] & {W{sel_lo[i]}});
            hi = hi | (vals[i] & {W{sel_hi[i]}});
        end
    end

    // Average the middle pair, rounding toward zero
    assign sum = {lo[W-1], lo} + {hi[W-1], hi};
    assign adj = sum + (W+1)'(sum[W]);

    assign can_load = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        median_next   = median_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            median_next   = adj[W:1];
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        median_reg <= median_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign median   = median_reg;

endmodule

### src/sliding_window_median_filter.sv
// Channel  | Ports                     | Contents (low bit up)
// ---------+---------------------------+----------------------------------
// input    | s_tvalid s_tready s_tdata | sample (signed), zero pad
// result   | m_tvalid m_tready m_tdata | median (signed), zero pad
// config   | cfg_we cfg_index cfg_wdata| 0: window_length, 1: fill_value
//
// One sample per cycle while the result channel is not stalled: a transaction shifts
// the sorted cell row in the cycle it is taken, and the median register then loads
// from the updated row once the result slot is free.
// Reset clears the window to zero with a length of three.
// A stalled result lets one more transaction into the row, then holds s_tready low.
module sliding_window_median_filter import smf_pkg::*; #(
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // median
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,
    input  logic                                      cfg_we,
    input  logic [CFG_IDX_W-1:0]                      cfg_index,
    input  logic [((SAMPLE_WIDTH > LEN_WIDTH) ? SAMPLE_WIDTH : LEN_WIDTH)-1:0] cfg_wdata
);

    localparam int W       = SAMPLE_WIDTH;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW      = $clog2(MAX_WINDOW + 1);

    logic [LEN_WIDTH-1:0] wlen_reg, wlen_next;
    logic [W-1:0]         fill_reg, fill_next;
    logic                 pend_reg, pend_next;
    logic                 refill;
    logic [W-1:0]         refill_val;
    logic [NW-1:0]        n_eff, lo_idx, hi_idx;
    logic [AW-1:0]        age_last;
    logic                 shift_en, load, can_load;
    logic [W-1:0]         sample, median;

    logic [MAX_WINDOW-1:0][W-1:0]  val_q;
    logic [MAX_WINDOW-1:0][AW-1:0] age_q;
    logic [MAX_WINDOW-1:0]         active, sel_lo, sel_hi;
    smf_link_t                     link [MAX_WINDOW+1];

    // Register writes; either one refills the window
    always_comb begin
        wlen_next  = wlen_reg;
        fill_next  = fill_reg;
        refill     = 1'b0;
        refill_val = fill_reg;
        if (cfg_we && cfg_index == REG_WINDOW_LENGTH) begin
            wlen_next = cfg_wdata[LEN_WIDTH-1:0];
            refill    = 1'b1;
        end else if (cfg_we && cfg_index == REG_FILL_VALUE) begin
            fill_next  = cfg_wdata[W-1:0];
            refill     = 1'b1;
            refill_val = cfg_wdata[W-1:0];
        end
    end

    // Clamp the length to the row size, treating zero as one
    always_comb begin
        if (wlen_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(wlen_reg) > 32'(MAX_WINDOW)) begin
            n_eff = NW'(MAX_WINDOW);
        end else begin
            n_eff = NW'(wlen_reg);
        end
    end

    assign age_last = AW'(n_eff - NW'(1));
    assign lo_idx   = (n_eff - NW'(1)) >> 1;
    assign hi_idx   = n_eff >> 1;

    // Handshake: one transaction waits in the row while the result slot drains
    assign sample   = s_tdata[W-1:0];
    assign s_tready = !pend_reg || can_load;
    assign shift_en = s_tvalid && s_tready;
    assign load     = pend_reg && can_load;

    always_comb begin
        pend_next = pend_reg;
        if (shift_en) begin
            pend_next = 1'b1;
        end else if (load) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= LEN_WIDTH'(3);
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            wlen_reg <= wlen_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    // Sorted cell row, lowest value at cell zero
    assign link[0] = '{le: 1'b1, del_before: 1'b0};

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic [W-1:0]  pv, nv;
        logic [AW-1:0] pa, na;
        logic          nle;

        assign active[i] = NW'(i) < n_eff;
        assign sel_lo[i] = NW'(i) == lo_idx;
        assign sel_hi[i] = NW'(i) == hi_idx;

        if (i == 0) begin : g_first
            assign pv = sample;
            assign pa = '0;
        end else begin : g_mid
            assign pv = val_q[i-1];
            assign pa = age_q[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign nv  = '0;
            assign na  = '0;
            assign nle = 1'b0;
        end else begin : g_inner
            assign nv  = val_q[i+1];
            assign na  = age_q[i+1];
            assign nle = link[i+2].le;
        end

        smf_cell #(
            .W   (W),
            .AW  (AW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (shift_en),
            .active     (active[i]),
            .refill     (refill),
            .refill_val (refill_val),
            .x          (sample),
            .age_last   (age_last),
            .prev_val   (pv),
            .prev_age   (pa),
            .link_in    (link[i]),
            .next_val   (nv),
            .next_age   (na),
            .next_le    (nle),
            .val_q      (val_q[i]),
            .age_q      (age_q[i]),
            .link_out   (link[i+1])
        );
    end

    // Middle pick and result register
    smf_median #(
        .W (W),
        .N (MAX_WINDOW)
    ) u_median (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .vals     (val_q),
        .sel_lo   (sel_lo),
        .sel_hi   (sel_hi),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .median   (median),
        .can_load (can_load)
    );

    assign m_tdata = TDATA_W'(median);

endmodule

### bench/tb_sliding_window_median_filter.sv
`timescale 1ns / 100ps

module tb_sliding_window_median_filter;
    import smf_pkg::*;

    localparam int MAX_WINDOW    = 16;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int DATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CFG_W         = (SAMPLE_WIDTH > LEN_WIDTH) ? SAMPLE_WIDTH : LEN_WIDTH;
    localparam int PERIOD        = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 100;
    localparam int CALM_PHASE    = 4;
    localparam int IDLE_PERCENT  = 6;

    // Indexes past the register list: the block must ignore these writes
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // sample
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // median
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predictor state: window contents, length and fill registers
    logic [LEN_WIDTH-1:0]          len_q;
    logic signed [SAMPLE_WIDTH-1:0] fill_q;
    logic signed [SAMPLE_WIDTH-1:0] win_q [MAX_WINDOW];

    logic [SAMPLE_WIDTH-1:0]        sample_queue [$];
    logic signed [SAMPLE_WIDTH-1:0] median_queue [$];
    int  in_flight    = 0;
    int  mismatches   = 0;
    int  stall_cycles = 0;
    bit  sample_taken = 1'b0;
    bit  calm         = 1'b0;

    sliding_window_median_filter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Shift a sample into the window and return the median of the active slots
    function automatic logic signed [SAMPLE_WIDTH-1:0] advance_window(
        input logic signed [SAMPLE_WIDTH-1:0] sample
    );
        int n;
        int i;
        int j;
        int v;
        int pair_sum;
        int sorted [MAX_WINDOW];
        for (i = MAX_WINDOW - 1; i > 0; i--) begin
            win_q[i] = win_q[i-1];
        end
        win_q[0] = sample;
        n = int'(len_q);
        if (n < 1) n = 1;
        if (n > MAX_WINDOW) n = MAX_WINDOW;
        // insertion sort of the active slots
        for (i = 0; i < n; i++) begin
            v = win_q[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (n % 2 == 1) begin
            return SAMPLE_WIDTH'(sorted[n/2]);
        end
        // even length: integer division truncates toward zero
        pair_sum = sorted[n/2-1] + sorted[n/2];
        return SAMPLE_WIDTH'(pair_sum / 2);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send(input logic [SAMPLE_WIDTH-1:0] sample);
        sample_queue.push_back(sample);
        in_flight++;
    endtask

    // Hold until every sample is taken and every median has come back
    task automatic drain();
        while (!(in_flight == 0 && median_queue.size() == 0)) @(negedge aclk);
    endtask

    // Write one register and mirror its effect in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        bit refill;
        refill = 1'b0;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        case (index)
            REG_WINDOW_LENGTH: begin
                len_q  = data[LEN_WIDTH-1:0];
                refill = 1'b1;
            end
            REG_FILL_VALUE: begin
                fill_q = data[SAMPLE_WIDTH-1:0];
                refill = 1'b1;
            end
            default: ;
        endcase
        if (refill) begin
            for (int i = 0; i < MAX_WINDOW; i++) win_q[i] = fill_q;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Present samples from the pending queue and toggle result back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || sample_taken) begin
                if (sample_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    s_tdata  <= sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
        sample_taken = 1'b0;
    end

    // Predict on each input transaction, check each result transaction
    always @(posedge aclk) begin
        logic signed [SAMPLE_WIDTH-1:0] want;
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                median_queue.push_back(advance_window(s_tdata[SAMPLE_WIDTH-1:0]));
                in_flight--;
                sample_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (median_queue.size() == 0) begin
                    report_mismatch($sformatf("median %0d with none expected",
                                              $signed(m_tdata[SAMPLE_WIDTH-1:0])));
                end else begin
                    want = median_queue.pop_front();
                    if (m_tdata[SAMPLE_WIDTH-1:0] !== want) begin
                        report_mismatch($sformatf("median got %0d expected %0d",
                                                  $signed(m_tdata[SAMPLE_WIDTH-1:0]), want));
                    end
                end
            end
        end
        if (moved || (in_flight == 0 && median_queue.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    // Abort when traffic stops while work is outstanding
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int p;
        int k;
        int r;
        logic [CFG_W-1:0]        word;
        logic [SAMPLE_WIDTH-1:0] fill_word;
        logic [SAMPLE_WIDTH-1:0] s;

        len_q  = LEN_WIDTH'(3);
        fill_q = '0;
        for (k = 0; k < MAX_WINDOW; k++) win_q[k] = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: extremes through a three-sample window
        send(S_MAX); send(S_MIN); send('0); send('1); send(16'd1); send(S_MIN); send(S_MAX);
        drain();

        // Even length with a negative fill: middle pair of opposite extremes
        write_reg(REG_FILL_VALUE, S_MIN);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(4));
        send(S_MAX); send(S_MAX); send(-16'sd3); send('1); send(-16'sd2);
        drain();

        // Writes past the register list leave the window untouched
        write_reg(REG_SPARE_2, 16'h000F);
        write_reg(REG_SPARE_3, 16'h5A5A);
        send(16'd7); send(-16'sd7);
        drain();

        // Zero length acts as a single slot
        write_reg(REG_WINDOW_LENGTH, '0);
        send(S_MIN); send(S_MAX);
        drain();

        // Length beyond the store saturates to the full window
        write_reg(REG_WINDOW_LENGTH, 16'hFFFF);
        send(S_MAX); send(16'd100); send(S_MIN);
        drain();

        // Upper data bits of the length register are dropped
        write_reg(REG_WINDOW_LENGTH, 16'hFFE2);
        send(16'd10); send(-16'sd11);
        drain();

        // Random phases, each with fresh register settings
        for (p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == CALM_PHASE);
            word = CFG_W'($urandom_range(1, MAX_WINDOW));
            r = $urandom_range(99);
            if (p == 0) begin
                word = CFG_W'(1);
            end else if (p == 1) begin
                word = CFG_W'(MAX_WINDOW);
            end else if (p == 2) begin
                word = CFG_W'(2);
            end else if (r < 15) begin
                word = CFG_W'($urandom_range(0, 31));
            end else if (r < 30) begin
                word[CFG_W-1:LEN_WIDTH] = (CFG_W - LEN_WIDTH)'($urandom);
            end

            fill_word = SAMPLE_WIDTH'($urandom);
            if (p == 2) begin
                fill_word = S_MAX;
            end else if ($urandom_range(99) < 30) begin
                fill_word = $urandom_range(1) ? S_MAX : S_MIN;
            end

            case (p < 3 ? 2 : $urandom_range(3))
                0: write_reg(REG_WINDOW_LENGTH, word);
                1: write_reg(REG_FILL_VALUE, fill_word);
                2: begin
                    write_reg(REG_WINDOW_LENGTH, word);
                    write_reg(REG_FILL_VALUE, fill_word);
                end
                default: begin
                    write_reg(REG_FILL_VALUE, fill_word);
                    write_reg(REG_WINDOW_LENGTH, word);
                end
            endcase
            if ($urandom_range(99) < 20) begin
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
            end

            // Mix full-range values, extremes and values clustered near the fill
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    s = SAMPLE_WIDTH'($urandom);
                end else if (r < 75) begin
                    case ($urandom_range(3))
                        0: s = S_MAX;
                        1: s = S_MIN;
                        2: s = '0;
                        default: s = '1;
                    endcase
                end else begin
                    s = fill_q + SAMPLE_WIDTH'(int'($urandom_range(0, 6)) - 3);
                end
                send(s);
            end
            drain();
        end

        calm = 1'b0;
        drain();
        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sliding_window_median_filter.f
src/smf_pkg.sv
src/smf_cell.sv
src/smf_median.sv
src/sliding_window_median_filter.sv
bench/tb_sliding_window_median_filter.sv
